[src/mrhd_pkg.sv]
// ============================================================================
// mrhd_pkg - shared types and constants for the ramped h-bridge drive
// Item structs, level constants, register indexes and reset values.
// ============================================================================
package mrhd_pkg;

    localparam int LEVEL_W = 12;
    localparam int DUTY_W  = 8;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int TICK_W  = 9;
    localparam int MAG_W   = 11;
    localparam int PROD_W  = MAG_W + DUTY_W;

    localparam logic [LEVEL_W-1:0] CENTER_LEVEL = 12'd2047;
    localparam logic [LEVEL_W-1:0] FWD_OFFSET   = 12'd2048;
    localparam logic [LEVEL_W-1:0] REV_OFFSET   = 12'd2046;
    localparam logic [PROD_W-1:0]  FWD_DIVISOR  = 19'd2047;
    localparam logic [PROD_W-1:0]  REV_DIVISOR  = 19'd2046;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TICKS = 2'd3;

    localparam logic [LEVEL_W-1:0] DEAD_BAND_RST      = 12'd100;
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RST       = 8'd255;
    localparam logic [LEVEL_W-1:0] SLEW_STEP_RST      = 12'd15;
    localparam logic [7:0]         INTERVAL_TICKS_RST = 8'd5;

    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] command_value;
    } drive_in_t;

    typedef struct packed {
        logic               drive_forward;
        logic               drive_reverse;
        logic [DUTY_W-1:0]  duty;
        logic [LEVEL_W-1:0] present_value;
    } drive_out_t;

    // level after the ramp update, and whether the drive outputs follow it
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               recompute;
    } ramp_item_t;

endpackage

[src/motor_ramp_hbridge_drive_top.sv]
// ============================================================================
// motor_ramp_hbridge_drive_top - slew-limited h-bridge drive
// Ramps a motor level toward a commanded target and derives bridge signals.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data take one item per handshake: func 0 sets a new
//   target from command_value (stop zone applied), func 1 is a 1 ms tick
//   that may advance the ramp. Every item returns exactly one result item
//   on m_valid/m_ready/m_data with the direction bits, duty and level.
//   One item can be taken every cycle while s_ready is high. The path is
//   ramp register, multiply register and result register; the duty divide
//   is a shift plus one compare-subtract. When the receiver stalls, each
//   stage holds and s_ready drops only once all three stages are full, so
//   items keep entering while a result waits.
//   cfg_wr_en/cfg_addr/cfg_wdata write one of the four control registers
//   per write; write them only while no item is in flight.
//   Synchronous active-low reset puts the level and target at center, the
//   tick counter at zero, the drive at coast and the registers at defaults.
// ============================================================================
module motor_ramp_hbridge_drive_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  mrhd_pkg::drive_in_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output mrhd_pkg::drive_out_t            m_data,
    input  logic                            cfg_wr_en,
    input  logic [mrhd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [mrhd_pkg::CFG_W-1:0]      cfg_wdata
);
    import mrhd_pkg::*;

    logic [LEVEL_W-1:0] dead_band_reg;
    logic [DUTY_W-1:0]  max_duty_reg;
    logic [LEVEL_W-1:0] slew_step_reg;
    logic [7:0]         interval_ticks_reg;

    logic               ramp_valid;
    logic               ramp_ready;
    ramp_item_t         ramp_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_band_reg      <= DEAD_BAND_RST;
            max_duty_reg       <= MAX_DUTY_RST;
            slew_step_reg      <= SLEW_STEP_RST;
            interval_ticks_reg <= INTERVAL_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEAD_BAND: begin
                    dead_band_reg <= cfg_wdata[LEVEL_W-1:0];
                end
                REG_MAX_DUTY: begin
                    max_duty_reg <= cfg_wdata[DUTY_W-1:0];
                end
                REG_SLEW_STEP: begin
                    slew_step_reg <= cfg_wdata[LEVEL_W-1:0];
                end
                REG_INTERVAL_TICKS: begin
                    interval_ticks_reg <= cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    mrhd_ramp u_ramp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .dead_band      (dead_band_reg),
        .slew_step      (slew_step_reg),
        .interval_ticks (interval_ticks_reg),
        .o_valid        (ramp_valid),
        .o_ready        (ramp_ready),
        .o_item         (ramp_item)
    );

    mrhd_duty u_duty (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .i_valid  (ramp_valid),
        .i_ready  (ramp_ready),
        .i_item   (ramp_item),
        .max_duty (max_duty_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[src/mrhd_ramp.sv]
// ============================================================================
// mrhd_ramp - target capture, tick counter and slew-limited level
// Updates the ramp state for each item and registers the resulting level.
// ============================================================================
module mrhd_ramp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mrhd_pkg::drive_in_t           s_data,
    input  logic [mrhd_pkg::LEVEL_W-1:0]  dead_band,
    input  logic [mrhd_pkg::LEVEL_W-1:0]  slew_step,
    input  logic [7:0]                    interval_ticks,
    output logic                          o_valid,
    input  logic                          o_ready,
    output mrhd_pkg::ramp_item_t          o_item
);
    import mrhd_pkg::*;

    logic [LEVEL_W-1:0] target_reg, target_next;
    logic [LEVEL_W-1:0] current_reg, current_next;
    logic [TICK_W-1:0]  count_reg, count_next;
    logic               valid_reg;
    ramp_item_t         item_reg;

    logic               accept;
    logic [LEVEL_W-1:0] cmd_offset;
    logic [TICK_W-1:0]  count_inc;
    logic               step_due;
    logic               up;
    logic [LEVEL_W-1:0] gap;
    logic [LEVEL_W-1:0] moved;

    assign s_ready = !valid_reg || o_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd_offset = (s_data.command_value >= CENTER_LEVEL) ?
                     s_data.command_value - CENTER_LEVEL :
                     CENTER_LEVEL - s_data.command_value;

        count_inc = count_reg + {{(TICK_W-1){1'b0}}, 1'b1};
        step_due  = count_inc > {1'b0, interval_ticks};

        // move by one step, landing on the target when the gap is smaller
        up  = current_reg < target_reg;
        gap = up ? target_reg - current_reg : current_reg - target_reg;
        if (slew_step >= gap) begin
            moved = target_reg;
        end else if (up) begin
            moved = current_reg + slew_step;
        end else begin
            moved = current_reg - slew_step;
        end

        target_next  = target_reg;
        current_next = current_reg;
        count_next   = count_reg;
        if (accept) begin
            if (!s_data.func) begin
                target_next = (cmd_offset < dead_band) ? CENTER_LEVEL : s_data.command_value;
            end else if (step_due) begin
                count_next   = '0;
                current_next = moved;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= CENTER_LEVEL;
            current_reg <= CENTER_LEVEL;
            count_reg   <= '0;
            valid_reg   <= 1'b0;
        end else begin
            target_reg  <= target_next;
            current_reg <= current_next;
            count_reg   <= count_next;
            if (s_ready) begin
                valid_reg <= s_valid;
            end
        end
        if (accept) begin
            item_reg.level     <= current_next;
            item_reg.recompute <= s_data.func && step_due;
        end
    end

    assign o_valid = valid_reg;
    assign o_item  = item_reg;

endmodule

[src/mrhd_duty.sv]
// ============================================================================
// mrhd_duty - direction and duty from the ramped level
// Scales the level offset by max_duty, divides by the span, holds outputs.
// ============================================================================
module mrhd_duty (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          i_valid,
    output logic                          i_ready,
    input  mrhd_pkg::ramp_item_t          i_item,
    input  logic [mrhd_pkg::DUTY_W-1:0]   max_duty,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mrhd_pkg::drive_out_t          m_data
);
    import mrhd_pkg::*;

    // product stage
    logic               prod_valid_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               fwd_reg;
    logic               rev_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               recompute_reg;

    // result stage
    logic               out_valid_reg;
    drive_out_t         out_reg;
    logic               held_forward_reg;
    logic               held_reverse_reg;
    logic [DUTY_W-1:0]  held_duty_reg;

    logic               out_ready;
    logic               fwd;
    logic               rev;
    logic [LEVEL_W-1:0] offset;
    logic [MAG_W-1:0]   mag;
    logic [DUTY_W-1:0]  quot;
    logic [PROD_W-1:0]  divisor;
    logic [PROD_W-1:0]  quot_times_div;
    logic [PROD_W-1:0]  rem;
    logic [DUTY_W-1:0]  duty_new;

    assign out_ready = !out_valid_reg || m_ready;
    assign i_ready   = !prod_valid_reg || out_ready;

    always_comb begin
        fwd    = i_item.level > CENTER_LEVEL;
        rev    = i_item.level < CENTER_LEVEL;
        offset = '0;
        if (fwd) begin
            offset = i_item.level - FWD_OFFSET;
        end else if (rev) begin
            offset = REV_OFFSET - i_item.level;
        end
        mag = offset[MAG_W-1:0];
    end

    // quotient by 2048 is at most one below the quotient by 2047 or 2046
    always_comb begin
        quot           = prod_reg[PROD_W-1:MAG_W];
        divisor        = fwd_reg ? FWD_DIVISOR : REV_DIVISOR;
        quot_times_div = {quot, {MAG_W{1'b0}}} -
                         (fwd_reg ? {{MAG_W{1'b0}}, quot} : {{(MAG_W-1){1'b0}}, quot, 1'b0});
        rem            = prod_reg - quot_times_div;
        duty_new       = quot + {{(DUTY_W-1){1'b0}}, (rem >= divisor)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            held_forward_reg <= 1'b0;
            held_reverse_reg <= 1'b0;
            held_duty_reg    <= '0;
        end else begin
            if (i_ready) begin
                prod_valid_reg <= i_valid;
            end
            if (out_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
            if (prod_valid_reg && out_ready && recompute_reg) begin
                held_forward_reg <= fwd_reg;
                held_reverse_reg <= rev_reg;
                held_duty_reg    <= duty_new;
            end
        end
        if (i_valid && i_ready) begin
            prod_reg      <= PROD_W'(mag) * PROD_W'(max_duty);
            fwd_reg       <= fwd;
            rev_reg       <= rev;
            level_reg     <= i_item.level;
            recompute_reg <= i_item.recompute;
        end
        if (prod_valid_reg && out_ready) begin
            out_reg.present_value <= level_reg;
            if (recompute_reg) begin
                out_reg.drive_forward <= fwd_reg;
                out_reg.drive_reverse <= rev_reg;
                out_reg.duty          <= duty_new;
            end else begin
                out_reg.drive_forward <= held_forward_reg;
                out_reg.drive_reverse <= held_reverse_reg;
                out_reg.duty          <= held_duty_reg;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
